@@ design/mafd_pkg.sv @@
`timescale 1ns / 1ps

package mafd_pkg;

  // Register indexes on the configuration port
  typedef enum logic [1:0] {
    REG_SYNC_WORD    = 2'd0,
    REG_HEADER_BYTE  = 2'd1,
    REG_FRAME_LENGTH = 2'd2
  } reg_index_t;

  // Reset values of the configuration registers
  localparam logic [31:0] SYNC_WORD_RESET    = 32'h669A_A9A9;
  localparam logic [7:0]  HEADER_BYTE_RESET  = 8'h65;
  localparam logic [7:0]  FRAME_LENGTH_RESET = 8'd240;

  // Framing constants
  localparam logic [4:0]  PHASE_LAST   = 5'd19;  // phase counts 0..19
  localparam logic [7:0]  FIRST_POS    = 8'd6;   // position after sync
  localparam logic [7:0]  HEADER_NEXT  = 8'd7;   // position after the header byte
  localparam logic [7:0]  POS_MAX      = 8'd255;
  localparam int          BITS_PER_IN  = 8;

  typedef struct packed {
    logic [31:0] sync_word;
    logic [7:0]  header_byte;
    logic [7:0]  frame_length;
  } cfg_t;

  typedef struct packed {
    logic [31:0] bit_history;
    logic [4:0]  phase_count;
    logic [9:0]  async_shift;
    logic [7:0]  write_position;
    logic        searching;
  } dstate_t;

  // Events from one channel bit
  typedef struct packed {
    logic       byte_valid;
    logic [7:0] data_byte;
    logic [7:0] byte_position;
    logic       frame_done;
    logic       start_error;
    logic       sync_found;
  } evt_t;

endpackage

@@ design/mafd_bit_step.sv @@
`timescale 1ns / 1ps

// One channel bit through the deframer state
module mafd_bit_step (
  input  mafd_pkg::cfg_t    cfg,
  input  mafd_pkg::dstate_t st,
  input  logic              chan_bit,
  output mafd_pkg::dstate_t st_next,
  output mafd_pkg::evt_t    evt
);

  logic [31:0] hist;
  logic [9:0]  async_reg;
  logic [4:0]  phase;
  logic [7:0]  wpos;
  logic [7:0]  dbyte;

  always_comb begin
    hist      = {st.bit_history[30:0], chan_bit};
    // async sampling on odd phase, also while searching
    async_reg = st.phase_count[0] ? {chan_bit, st.async_shift[9:1]} : st.async_shift;
    phase     = (st.phase_count == mafd_pkg::PHASE_LAST) ? 5'd0 : st.phase_count + 5'd1;
    dbyte     = async_reg[8:1];
    wpos      = (st.write_position < mafd_pkg::POS_MAX) ?
                st.write_position + 8'd1 : st.write_position;

    st_next             = st;
    st_next.bit_history = hist;
    st_next.async_shift = async_reg;
    evt                 = '0;

    if (st.searching) begin
      // hunt for the sync word
      if (hist == cfg.sync_word) begin
        st_next.searching      = 1'b0;
        st_next.phase_count    = 5'd0;
        st_next.write_position = mafd_pkg::FIRST_POS;
        evt.sync_found         = 1'b1;
      end
    end else begin
      st_next.phase_count = phase;
      if (phase == 5'd0) begin
        evt.byte_valid         = 1'b1;
        evt.data_byte          = dbyte;
        evt.byte_position      = st.write_position;
        st_next.write_position = wpos;
        if (wpos == mafd_pkg::HEADER_NEXT && dbyte != cfg.header_byte) begin
          st_next.searching = 1'b1;
          evt.start_error   = 1'b1;
        end
        if (wpos >= cfg.frame_length || wpos == mafd_pkg::POS_MAX) begin
          st_next.searching = 1'b1;
          evt.frame_done    = 1'b1;
        end
      end
    end
  end

endmodule

@@ design/mafd_core.sv @@
`timescale 1ns / 1ps

// Deframer state register and the eight chained bit steps of one raw byte
module mafd_core (
  input  logic           clk,
  input  logic           rst,
  input  mafd_pkg::cfg_t cfg,
  input  logic           advance,
  input  logic [7:0]     raw_byte,
  output mafd_pkg::evt_t evt
);

  mafd_pkg::dstate_t st;
  mafd_pkg::dstate_t chain [mafd_pkg::BITS_PER_IN+1];
  mafd_pkg::evt_t    bit_evt [mafd_pkg::BITS_PER_IN];

  assign chain[0] = st;

  // MSB first through the steps
  for (genvar g = 0; g < mafd_pkg::BITS_PER_IN; g++) begin : g_step
    mafd_bit_step u_step (
      .cfg      (cfg),
      .st       (chain[g]),
      .chan_bit (raw_byte[mafd_pkg::BITS_PER_IN-1-g]),
      .st_next  (chain[g+1]),
      .evt      (bit_evt[g])
    );
  end

  // Merge events; at most one byte completes per raw byte, so OR is exact
  always_comb begin
    evt = '0;
    for (int i = 0; i < mafd_pkg::BITS_PER_IN; i++) begin
      evt = evt | bit_evt[i];
    end
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      st.bit_history    <= '0;
      st.phase_count    <= '0;
      st.async_shift    <= '0;
      st.write_position <= '0;
      st.searching      <= 1'b1;
    end else if (advance) begin
      st <= chain[mafd_pkg::BITS_PER_IN];
    end
  end

endmodule

@@ design/manchester_async_frame_deframer_unit.sv @@
`timescale 1ns / 1ps
// A result is on m_tvalid in the cycle after its raw byte's transfer.
// One raw byte per cycle while m_tvalid is low or m_tready is high; the eight
// channel bits pass a combinational chain of bit steps before the result register.
// Reset (rst, synchronous): searching for sync, history/phase/shift/position
// cleared, registers back to their defaults, no result pending.
module manchester_async_frame_deframer_unit (
  input  logic        clk,
  input  logic        rst,
  // configuration writes
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  // raw byte stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] raw_byte
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [0] byte_valid, [8:1] data_byte, [16:9] byte_position,
                                 // [17] start_error, [18] sync_found, [23:19] zero
  output logic        m_tlast    // frame_done
);

  mafd_pkg::cfg_t cfg;
  mafd_pkg::evt_t evt;
  mafd_pkg::evt_t res;
  logic           s_xfer;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sync_word    <= mafd_pkg::SYNC_WORD_RESET;
      cfg.header_byte  <= mafd_pkg::HEADER_BYTE_RESET;
      cfg.frame_length <= mafd_pkg::FRAME_LENGTH_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mafd_pkg::REG_SYNC_WORD:    cfg.sync_word    <= cfg_data;
        mafd_pkg::REG_HEADER_BYTE:  cfg.header_byte  <= cfg_data[7:0];
        mafd_pkg::REG_FRAME_LENGTH: cfg.frame_length <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Take a new byte whenever the result register is free or being drained
  assign s_tready = !m_tvalid || m_tready;
  assign s_xfer   = s_tvalid && s_tready;

  mafd_core u_core (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .advance  (s_xfer),
    .raw_byte (s_tdata),
    .evt      (evt)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_xfer) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_xfer) begin
      res <= evt;
    end
  end

  assign m_tdata = {5'd0, res.sync_found, res.start_error, res.byte_position,
                    res.data_byte, res.byte_valid};
  assign m_tlast = res.frame_done;

  // A frame ends only on an emitted byte
  a_done_has_byte: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> res.byte_valid)
    else $error("frame_done without a decoded byte");

  // A header mismatch is reported on the byte at the first frame position
  a_err_at_header: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && res.start_error |-> res.byte_valid &&
                                    res.byte_position == mafd_pkg::FIRST_POS)
    else $error("start_error away from the header byte");

  // Decoded bytes never sit before the header position
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && res.byte_valid |-> res.byte_position >= mafd_pkg::FIRST_POS)
    else $error("byte_position below the header position");

  // Nothing is pending right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result pending after reset");

endmodule

@@ tb/sv/tb_manchester_async_frame_deframer_unit.sv @@
`timescale 1ns / 1ps

module tb_manchester_async_frame_deframer_unit;

  localparam int ITEM_TARGET = 1450;
  localparam int LONG_HOLD   = 160;

  typedef bit bitq_t[$];

  // Deframer prediction and result checking
  class deframe_checker;
    logic [31:0] sync_word;
    logic [7:0]  header_byte;
    logic [7:0]  frame_length;
    logic [31:0] bit_history;
    logic [4:0]  phase_count;
    logic [9:0]  async_shift;
    logic [7:0]  write_position;
    logic        searching;
    mafd_pkg::evt_t decode_q[$];
    int          mismatches;

    function new();
      sync_word      = mafd_pkg::SYNC_WORD_RESET;
      header_byte    = mafd_pkg::HEADER_BYTE_RESET;
      frame_length   = mafd_pkg::FRAME_LENGTH_RESET;
      bit_history    = '0;
      phase_count    = '0;
      async_shift    = '0;
      write_position = '0;
      searching      = 1'b1;
      mismatches     = 0;
    endfunction

    function void set_config(logic [31:0] sync_v, logic [7:0] hdr_v, logic [7:0] len_v);
      sync_word    = sync_v;
      header_byte  = hdr_v;
      frame_length = len_v;
    endfunction

    // Run the eight channel bits of one raw byte, MSB first
    function void note_raw_byte(logic [7:0] raw);
      mafd_pkg::evt_t ev;
      logic b;
      ev = '0;
      for (int i = 7; i >= 0; i--) begin
        b = raw[i];
        bit_history = {bit_history[30:0], b};
        // second Manchester half lands in the async register on odd phases
        if (phase_count[0]) async_shift = {b, async_shift[9:1]};
        if (searching) begin
          if (bit_history == sync_word) begin
            searching      = 1'b0;
            phase_count    = '0;
            write_position = mafd_pkg::FIRST_POS;
            ev.sync_found  = 1'b1;
          end
        end else begin
          phase_count = (phase_count == mafd_pkg::PHASE_LAST) ? 5'd0 : phase_count + 5'd1;
          if (phase_count == 5'd0) begin
            ev.byte_valid    = 1'b1;
            ev.data_byte     = async_shift[8:1];
            ev.byte_position = write_position;
            if (write_position != mafd_pkg::POS_MAX) write_position = write_position + 8'd1;
            // wrong header byte abandons the frame
            if (write_position == mafd_pkg::HEADER_NEXT &&
                async_shift[8:1] != header_byte) begin
              searching      = 1'b1;
              ev.start_error = 1'b1;
            end
            if (write_position >= frame_length || write_position == mafd_pkg::POS_MAX) begin
              searching     = 1'b1;
              ev.frame_done = 1'b1;
            end
          end
        end
      end
      decode_q.push_back(ev);
    endfunction

    function void check_decode_event(logic [23:0] tdata, logic tlast);
      mafd_pkg::evt_t want, got;
      got.byte_valid    = tdata[0];
      got.data_byte     = tdata[8:1];
      got.byte_position = tdata[16:9];
      got.start_error   = tdata[17];
      got.sync_found    = tdata[18];
      got.frame_done    = tlast;
      if (decode_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("decode result with nothing pending: tdata=%h tlast=%b", tdata, tlast);
        return;
      end
      want = decode_q.pop_front();
      if (got.byte_valid !== want.byte_valid || got.data_byte !== want.data_byte ||
          got.byte_position !== want.byte_position || got.frame_done !== want.frame_done ||
          got.start_error !== want.start_error || got.sync_found !== want.sync_found) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"decode mismatch: want v%b d%h p%0d f%b e%b s%b",
                    " / got v%b d%h p%0d f%b e%b s%b"},
                   want.byte_valid, want.data_byte, want.byte_position, want.frame_done,
                   want.start_error, want.sync_found, got.byte_valid, got.data_byte,
                   got.byte_position, got.frame_done, got.start_error, got.sync_found);
      end
    endfunction
  endclass

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        cfg_we    = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data  = '0;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata   = '0;   // [7:0] raw_byte
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [23:0] m_tdata;         // [0] byte_valid, [8:1] data_byte, [16:9] byte_position,
                                // [17] start_error, [18] sync_found, [23:19] zero
  logic        m_tlast;         // frame_done

  deframe_checker sb = new();
  bit    chan_bits[$];
  int    raw_sent = 0;
  bit    calm     = 1'b0;
  bit    burst    = 1'b0;
  bit    hold_now = 1'b0;

  manchester_async_frame_deframer_unit dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Transfer monitor: predict on input transfers, check on output transfers
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) sb.note_raw_byte(s_tdata);
      if (m_tvalid && m_tready) sb.check_decode_event(m_tdata, m_tlast);
    end
  end

  // Mostly short idle gaps, a few long ones
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void push_noise(input int n);
    repeat (n) chan_bits.push_back(bit'($urandom_range(0, 1)));
  endfunction

  // low n bits of v, oldest channel bit first
  function automatic void push_word(input logic [31:0] v, input int n);
    for (int i = n - 1; i >= 0; i--) chan_bits.push_back(v[i]);
  endfunction

  // Manchester-coded 8N1 bytes for positions 6 and up
  function automatic bitq_t frame_payload(input int n_bytes, input bit hdr_ok,
                                          input logic [7:0] hdr);
    bitq_t      q;
    logic [9:0] word;
    logic [7:0] d;
    for (int p = 0; p < n_bytes; p++) begin
      d = 8'($urandom_range(0, 255));
      if (p == 0) d = hdr_ok ? hdr : hdr ^ 8'($urandom_range(1, 255));
      // stop bit is not checked, so it is sometimes wrong
      word = {bit'($urandom_range(0, 9) != 0), d, 1'b0};
      for (int j = 0; j < 10; j++) begin
        q.push_back(!word[j]);
        q.push_back(word[j]);
      end
    end
    return q;
  endfunction

  task automatic send_raw(input logic [7:0] raw);
    int gap;
    gap = burst ? 0 : pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= raw;
    @(posedge clk iff s_tready);
    raw_sent++;
  endtask

  // Pack queued channel bits into raw bytes, MSB first
  task automatic send_channel(input bit pad);
    logic [7:0] raw;
    if (pad) while (chan_bits.size() % 8 != 0) chan_bits.push_back(bit'($urandom_range(0, 1)));
    while (chan_bits.size() >= 8) begin
      for (int i = 7; i >= 0; i--) raw[i] = chan_bits.pop_front();
      send_raw(raw);
    end
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.decode_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_config(input logic [31:0] sync_v, input logic [7:0] hdr_v,
                              input logic [7:0] len_v);
    cfg_we    <= 1'b1;
    cfg_index <= mafd_pkg::REG_SYNC_WORD;
    cfg_data  <= sync_v;
    @(posedge clk);
    cfg_index <= mafd_pkg::REG_HEADER_BYTE;
    cfg_data  <= {24'd0, hdr_v};
    @(posedge clk);
    cfg_index <= mafd_pkg::REG_FRAME_LENGTH;
    cfg_data  <= {24'd0, len_v};
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_config(sync_v, hdr_v, len_v);
  endtask

  task automatic random_phase();
    logic [31:0] sync_v;
    logic [7:0]  hdr_v, len_v;
    bitq_t       pay;
    int          sel, n_bytes, k, noise, tail, idx;
    sel = $urandom_range(0, 9);
    case (sel)
      0:       sync_v = 32'h0000_0000;
      1:       sync_v = 32'hFFFF_FFFF;
      2, 3:    sync_v = mafd_pkg::SYNC_WORD_RESET;
      default: sync_v = $urandom();
    endcase
    sel = $urandom_range(0, 9);
    hdr_v = (sel == 0) ? 8'h00 : (sel == 1) ? 8'hFF : 8'($urandom_range(0, 255));
    sel = $urandom_range(0, 9);
    len_v = (sel < 2) ? 8'd8 :
            (sel < 8) ? 8'($urandom_range(9, 20)) : 8'($urandom_range(21, 60));
    n_bytes = int'(len_v) - int'(mafd_pkg::FIRST_POS);
    calm = ($urandom_range(0, 3) == 0);

    if ($urandom_range(0, 3) == 0) begin
      // Sync word = tail of a complete frame plus k fresh bits, so the frame
      // end and the next sync match fall in the same raw byte
      k   = $urandom_range(1, 4);
      pay = frame_payload(n_bytes, 1'b1, hdr_v);
      for (int i = 0; i < 32; i++)
        sync_v[i] = (i < k) ? bit'($urandom_range(0, 1)) : pay[pay.size() - 1 - (i - k)];
      write_config(sync_v, hdr_v, len_v);
      noise = $urandom_range(0, 15);
      tail  = (chan_bits.size() + noise + 32 + pay.size()) % 8;
      while (tail == 0 || tail > 8 - k) begin
        noise++;
        tail = (tail + 1) % 8;
      end
      push_noise(noise);
      push_word(sync_v, 32);
      chan_bits = {chan_bits, pay};
      push_word(sync_v, k);
      chan_bits = {chan_bits, frame_payload(n_bytes, 1'b1, hdr_v)};
      send_channel(1'b0);
    end else begin
      write_config(sync_v, hdr_v, len_v);
      repeat ($urandom_range(2, 5)) begin
        push_noise($urandom_range(0, 24));
        push_word(sync_v, 32);
        sel = $urandom_range(0, 9);
        pay = frame_payload(n_bytes, sel != 0, hdr_v);
        // broken frames: cut short, or one channel bit flipped
        if (sel == 1) repeat ($urandom_range(1, 19)) void'(pay.pop_back());
        if (sel == 2) begin
          idx = $urandom_range(0, pay.size() - 1);
          pay[idx] = !pay[idx];
        end
        chan_bits = {chan_bits, pay};
        send_channel(1'b0);
      end
    end
    push_noise($urandom_range(0, 16));
    send_channel(1'b1);
    drain();
  endtask

  // Receiver: random ready pattern, one long hold on request
  initial begin : result_sink
    int run_len;
    @(posedge clk iff !rst);
    forever begin
      if (hold_now) begin
        hold_now = 1'b0;
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      m_tready <= 1'b1;
      repeat ($urandom_range(1, 30)) @(posedge clk);
      run_len = pick_gap();
      if (run_len > 0) begin
        m_tready <= 1'b0;
        repeat (run_len) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // raw byte extremes while searching, reset configuration
    send_raw(8'h00);
    send_raw(8'hFF);
    send_raw(8'hAA);
    send_raw(8'h55);
    send_raw(8'h01);
    send_raw(8'h80);
    drain();

    // shortest frame, then a frame with a wrong header byte
    write_config(mafd_pkg::SYNC_WORD_RESET, mafd_pkg::HEADER_BYTE_RESET, 8'd8);
    push_word(mafd_pkg::SYNC_WORD_RESET, 32);
    chan_bits = {chan_bits, frame_payload(2, 1'b1, mafd_pkg::HEADER_BYTE_RESET)};
    send_channel(1'b1);
    push_word(mafd_pkg::SYNC_WORD_RESET, 32);
    chan_bits = {chan_bits, frame_payload(1, 1'b0, mafd_pkg::HEADER_BYTE_RESET)};
    send_channel(1'b1);
    drain();

    random_phase();
    random_phase();

    // sender streams without gaps while the receiver holds off
    write_config(mafd_pkg::SYNC_WORD_RESET, mafd_pkg::HEADER_BYTE_RESET, 8'd16);
    burst    = 1'b1;
    hold_now = 1'b1;
    repeat (3) begin
      push_noise($urandom_range(0, 12));
      push_word(mafd_pkg::SYNC_WORD_RESET, 32);
      chan_bits = {chan_bits, frame_payload(10, 1'b1, mafd_pkg::HEADER_BYTE_RESET)};
    end
    send_channel(1'b1);
    burst = 1'b0;
    drain();

    // longest frame: runs to the position limit
    write_config(mafd_pkg::SYNC_WORD_RESET, 8'($urandom_range(0, 255)), mafd_pkg::POS_MAX);
    push_noise(5);
    push_word(mafd_pkg::SYNC_WORD_RESET, 32);
    chan_bits = {chan_bits,
                 frame_payload(int'(mafd_pkg::POS_MAX) - int'(mafd_pkg::FIRST_POS), 1'b1,
                               sb.header_byte)};
    push_noise(20);
    send_channel(1'b1);
    drain();

    while (raw_sent < ITEM_TARGET) random_phase();

    repeat (10) @(posedge clk);
    if (sb.decode_q.size() != 0)
      $display("%0d decode results never arrived", sb.decode_q.size());
    if (sb.mismatches == 0 && sb.decode_q.size() == 0) begin
      $display("manchester_async_frame_deframer_unit test passed");
    end else begin
      $display("manchester_async_frame_deframer_unit test failed");
    end
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("manchester_async_frame_deframer_unit test failed");
    $finish;
  end

endmodule

@@ manchester_async_frame_deframer_unit.f @@
design/mafd_pkg.sv
design/mafd_bit_step.sv
design/mafd_core.sv
design/manchester_async_frame_deframer_unit.sv
tb/sv/tb_manchester_async_frame_deframer_unit.sv
